>>> hdl/lgws_pkg.sv
package lgws_pkg;

  // Sync bytes that open every framed byte, and the high-nibble mask.
  localparam logic [7:0] SyncCmd  = 8'hF8;
  localparam logic [7:0] SyncData = 8'hFA;
  localparam logic [7:0] NibbleHi = 8'hF0;

  // Controller instructions.
  localparam logic [7:0] CmdBasicAlpha = 8'h20;
  localparam logic [7:0] CmdEntryMode  = 8'h06;
  localparam logic [7:0] CmdDisplayOn  = 8'h0C;
  localparam logic [7:0] CmdExtGraphic = 8'h26;
  localparam logic [3:0] CmdGdramAddr  = 4'h8;

  // Request opcodes.
  localparam logic OpInit = 1'b0;
  localparam logic OpDraw = 1'b1;

  // Position inside one framed byte.
  localparam logic [1:0] PhSync = 2'd0;
  localparam logic [1:0] PhHi   = 2'd1;
  localparam logic [1:0] PhLo   = 2'd2;

  // Microprogram entry points.
  localparam int unsigned PcWidth = 4;
  localparam logic [PcWidth-1:0] PcInit  = 4'd0;
  localparam logic [PcWidth-1:0] PcExt   = 4'd4;
  localparam logic [PcWidth-1:0] PcGdram = 4'd5;

  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_ROW_ADDR,
    SRC_COL_ADDR,
    SRC_PIX_HI,
    SRC_PIX_LO
  } src_e;

  typedef struct packed {
    logic       is_data;   // data sync instead of command sync
    src_e       src;
    logic [7:0] const_byte;
    logic       end_step;  // final framed byte of the routine
  } ctrl_word_t;

  typedef struct packed {
    logic       load;      // a byte is handed to the output register
    ctrl_word_t cw;
    logic [1:0] phase;
    logic       last;
  } emit_t;

  typedef struct packed {
    logic busy;
    logic ext_mode;
    logic gfx_mode;
  } seq_status_t;

  // Microprogram: one control word per framed byte.
  function automatic ctrl_word_t ucode_rom(input logic [PcWidth-1:0] pc);
    ctrl_word_t cw;
    cw = '{is_data: 1'b0, src: SRC_CONST, const_byte: 8'h00, end_step: 1'b1};
    unique case (pc)
      4'd0: cw = '{1'b0, SRC_CONST,    CmdBasicAlpha, 1'b0};
      4'd1: cw = '{1'b0, SRC_CONST,    CmdBasicAlpha, 1'b0};
      4'd2: cw = '{1'b0, SRC_CONST,    CmdEntryMode,  1'b0};
      4'd3: cw = '{1'b0, SRC_CONST,    CmdDisplayOn,  1'b1};
      4'd4: cw = '{1'b0, SRC_CONST,    CmdExtGraphic, 1'b0};
      4'd5: cw = '{1'b0, SRC_ROW_ADDR, 8'h00,         1'b0};
      4'd6: cw = '{1'b0, SRC_COL_ADDR, 8'h00,         1'b0};
      4'd7: cw = '{1'b1, SRC_PIX_HI,   8'h00,         1'b0};
      4'd8: cw = '{1'b1, SRC_PIX_LO,   8'h00,         1'b1};
      default: cw = '{1'b0, SRC_CONST, 8'h00,         1'b1};
    endcase
    return cw;
  endfunction

endpackage

>>> hdl/lgws_sequencer.sv
module lgws_sequencer
  import lgws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        op_i,
  input  logic        out_free_i,
  output emit_t       emit_o,
  output seq_status_t status_o
);

  logic               busy_q, busy_d;
  logic [PcWidth-1:0] pc_q, pc_d;
  logic [1:0]         phase_q, phase_d;
  logic               ext_q, ext_d;
  logic               gfx_q, gfx_d;
  ctrl_word_t         cw;
  logic               step;

  assign cw   = ucode_rom(pc_q);
  assign step = busy_q && out_free_i;

  always_comb begin
    busy_d  = busy_q;
    pc_d    = pc_q;
    phase_d = phase_q;
    ext_d   = ext_q;
    gfx_d   = gfx_q;
    if (accept_i) begin
      phase_d = PhSync;
      if (op_i == OpInit) begin
        busy_d = 1'b1;
        pc_d   = PcInit;
        ext_d  = 1'b0;
        gfx_d  = 1'b1;
      end else if (gfx_q) begin
        // Conditional jump: skip the mode switch once extended mode is on.
        busy_d = 1'b1;
        pc_d   = ext_q ? PcGdram : PcExt;
        ext_d  = 1'b1;
      end
    end else if (step) begin
      unique case (phase_q)
        PhSync: phase_d = PhHi;
        PhHi:   phase_d = PhLo;
        default: begin
          phase_d = PhSync;
          if (cw.end_step) begin
            busy_d = 1'b0;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pc_q    <= PcInit;
      phase_q <= PhSync;
      ext_q   <= 1'b0;
      gfx_q   <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      pc_q    <= pc_d;
      phase_q <= phase_d;
      ext_q   <= ext_d;
      gfx_q   <= gfx_d;
    end
  end

  assign emit_o.load  = step;
  assign emit_o.cw    = cw;
  assign emit_o.phase = phase_q;
  assign emit_o.last  = cw.end_step && (phase_q == PhLo);

  assign status_o.busy     = busy_q;
  assign status_o.ext_mode = ext_q;
  assign status_o.gfx_mode = gfx_q;

endmodule

>>> hdl/lgws_datapath.sv
module lgws_datapath
  import lgws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [2:0]  col_i,
  input  logic [5:0]  row_i,
  input  logic [15:0] pixel_word_i,
  input  emit_t       emit_i,
  output logic        out_free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  serial_byte_o,
  output logic        last_o
);

  logic [2:0]  col_q;
  logic [5:0]  row_q;
  logic [15:0] pixel_q;
  logic        out_valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        last_q;
  logic [7:0]  payload;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      col_q   <= col_i;
      row_q   <= row_i;
      pixel_q <= pixel_word_i;
    end
  end

  always_comb begin
    case (emit_i.cw.src)
      SRC_ROW_ADDR: payload = {CmdGdramAddr, 4'h0} | {3'b000, row_q[4:0]};
      SRC_COL_ADDR: payload = {CmdGdramAddr, row_q[5], col_q};
      SRC_PIX_HI:   payload = pixel_q[15:8];
      SRC_PIX_LO:   payload = pixel_q[7:0];
      default:      payload = emit_i.cw.const_byte;
    endcase
  end

  always_comb begin
    unique case (emit_i.phase)
      PhSync:  byte_d = emit_i.cw.is_data ? SyncData : SyncCmd;
      PhHi:    byte_d = payload & NibbleHi;
      default: byte_d = {payload[3:0], 4'h0};
    endcase
  end

  assign out_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free_o) begin
      out_valid_q <= emit_i.load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.load && out_free_o) begin
      byte_q <= byte_d;
      last_q <= emit_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign serial_byte_o = byte_q;
  assign last_o        = last_q;

endmodule

>>> hdl/lcd_gdram_write_serializer.sv
// Serializer from display requests to the byte stream of a three-byte
// serial LCD framing.
// The input channel (in_valid_i/in_ready_o) carries one request per
// transfer: op_i selects initialize or draw, and col_i, row_i and
// pixel_word_i give the target word and its sixteen pixels for a draw.
// The output channel (out_valid_o/out_ready_i) carries one serial byte per
// transfer, with last_o high on the final byte of a request's run.
// A request is accepted only while the sequencer is idle. Its first byte
// goes from the sequencer through the output register, and bytes then
// follow one per cycle as long as the receiver takes them. An initialize
// request yields 12 bytes, a draw 12 or 15. The rate is set by the
// microcode sequencer, which steps through one output byte per cycle
// while the output register is free.
// A draw that arrives before the first initialize is accepted and dropped.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits; the final byte may still sit in the output register
// when the next request is accepted.
// Reset clears the mode flags, so a draw is ignored until initialization.
module lcd_gdram_write_serializer
  import lgws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [2:0]  col_i,
  input  logic [5:0]  row_i,
  input  logic [15:0] pixel_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  serial_byte_o,
  output logic        last_o
);

  emit_t       emit;
  seq_status_t status;
  logic        out_free;
  logic        accept;

  // Requests are taken only between runs.
  assign in_ready_o = !status.busy;
  assign accept     = in_valid_i && in_ready_o;

  // Program counter, byte phase and mode flags.
  lgws_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op_i),
    .out_free_i (out_free),
    .emit_o     (emit),
    .status_o   (status)
  );

  // Operand latch, byte builder and output register.
  lgws_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .col_i         (col_i),
    .row_i         (row_i),
    .pixel_word_i  (pixel_word_i),
    .emit_i        (emit),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .serial_byte_o (serial_byte_o),
    .last_o        (last_o)
  );

  // An initialize always leaves graphics mode on and extended mode off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == OpInit) |=> status.gfx_mode && !status.ext_mode)
    else $error("init did not set the mode flags");

  // A draw before initialization starts no run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == OpDraw) && !status.gfx_mode |=> !status.busy)
    else $error("draw before init started a run");

  // A run starts only through an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.busy) |-> $past(accept))
    else $error("sequencer started without a request");

  // Extended mode is only ever on once graphics mode is on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.ext_mode |-> status.gfx_mode)
    else $error("extended mode without initialization");

endmodule

>>> sim/tb_lcd_gdram_write_serializer.sv
module tb_lcd_gdram_write_serializer;
  import lgws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The run ends here even if the block hangs. The slowest run is 133 requests
  // of up to 15 bytes each, some behind a receiver that stalls most cycles.
  localparam int CycleLimit = 400000;
  // Quiet cycles after the last expected byte, so that a stray extra byte
  // or a late draw still has room to show up.
  localparam int DrainCycles = 64;
  localparam int RandPerPhase = 30;
  localparam int MaxReported = 10;

  // One row of the directed table. Where hand_checked is set, exp_bytes
  // holds the byte run (first byte in the top eight bits, left-aligned)
  // and exp_count its length. The final byte carries last.
  typedef struct packed {
    logic         op;
    logic [2:0]   col;
    logic [5:0]   row;
    logic [15:0]  pix;
    logic         hand_checked;
    logic [3:0]   exp_count;
    logic [119:0] exp_bytes;
  } dir_row_t;

  localparam int DirRows = 13;

  // Initialize always gives the same twelve bytes: 0x20 twice, then 0x06
  // and 0x0C, each split into sync, high nibble and low nibble.
  localparam logic [119:0] InitRun = {
    8'hF8, 8'h20, 8'h00, 8'hF8, 8'h20, 8'h00,
    8'hF8, 8'h00, 8'h60, 8'hF8, 8'h00, 8'hC0, 24'h0
  };

  localparam dir_row_t DirTab [DirRows] = '{
    // Draws before the first initialize are swallowed without output.
    '{OpDraw, 3'd7, 6'd63, 16'hFFFF, 1'b1, 4'd0, 120'h0},
    '{OpDraw, 3'd0, 6'd0,  16'h0000, 1'b1, 4'd0, 120'h0},
    // Initialize ignores its position and pixel fields.
    '{OpInit, 3'd7, 6'd63, 16'hFFFF, 1'b1, 4'd12, InitRun},
    // First draw switches to extended graphics first: all fields at max.
    '{OpDraw, 3'd7, 6'd63, 16'hFFFF, 1'b1, 4'd15, {
      8'hF8, 8'h20, 8'h60, 8'hF8, 8'h90, 8'hF0, 8'hF8, 8'h80, 8'hF0,
      8'hFA, 8'hF0, 8'hF0, 8'hFA, 8'hF0, 8'hF0}},
    // Already in extended mode, all fields at zero.
    '{OpDraw, 3'd0, 6'd0,  16'h0000, 1'b1, 4'd12, {
      8'hF8, 8'h80, 8'h00, 8'hF8, 8'h80, 8'h00,
      8'hFA, 8'h00, 8'h00, 8'hFA, 8'h00, 8'h00, 24'h0}},
    '{OpDraw, 3'd0, 6'd32, 16'h8001, 1'b0, 4'd0, 120'h0},
    '{OpDraw, 3'd7, 6'd31, 16'h00FF, 1'b0, 4'd0, 120'h0},
    // Initialize again, twice back to back; each sends the full run.
    '{OpInit, 3'd0, 6'd0,  16'h0000, 1'b1, 4'd12, InitRun},
    '{OpInit, 3'd5, 6'd42, 16'h5A5A, 1'b1, 4'd12, InitRun},
    // After the re-init the extended switch must come again.
    '{OpDraw, 3'd3, 6'd45, 16'hA55A, 1'b0, 4'd0, 120'h0},
    '{OpDraw, 3'd4, 6'd18, 16'h5AA5, 1'b0, 4'd0, 120'h0},
    '{OpDraw, 3'd1, 6'd33, 16'h1234, 1'b0, 4'd0, 120'h0},
    '{OpDraw, 3'd6, 6'd1,  16'hFEDC, 1'b0, 4'd0, 120'h0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        op_i;
  logic [2:0]  col_i;
  logic [5:0]  row_i;
  logic [15:0] pixel_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  serial_byte_o;
  logic        last_o;

  // Travels with the request payload so that the monitor knows whether the
  // transfer it sees carries a hand-written byte run.
  logic         cur_hand_checked;
  logic [3:0]   cur_exp_count;
  logic [119:0] cur_exp_bytes;

  // Predictor copy of the controller mode flags.
  logic ext_mode_q;
  logic gfx_mode_q;

  // Each entry is {last, serial byte}.
  logic [8:0] frame_q[$];
  logic [8:0] pending_bytes_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int n_errors;
  int cycle_cnt = 0;

  lcd_gdram_write_serializer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .pixel_word_i (pixel_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .serial_byte_o(serial_byte_o),
    .last_o       (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Receiver side: ready is redrawn every cycle from the current stall rate.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One command or data byte goes out as a sync byte, then its high nibble
  // in place, then its low nibble moved up into the high half.
  function automatic void push_framed(input logic [7:0] sync, input logic [7:0] cmd);
    frame_q.push_back({1'b0, sync});
    frame_q.push_back({1'b0, cmd & NibbleHi});
    frame_q.push_back({1'b0, cmd[3:0], 4'h0});
  endfunction

  // Builds the byte run of one accepted request into frame_q and advances
  // the mode flags. A draw while graphics mode is still off leaves both the
  // run and the flags empty and untouched.
  function automatic void frame_request(input logic op, input logic [2:0] col,
                                        input logic [5:0] row, input logic [15:0] pix);
    frame_q.delete();
    if (op == OpInit) begin
      push_framed(SyncCmd, CmdBasicAlpha);
      push_framed(SyncCmd, CmdBasicAlpha);
      push_framed(SyncCmd, CmdEntryMode);
      push_framed(SyncCmd, CmdDisplayOn);
      ext_mode_q = 1'b0;
      gfx_mode_q = 1'b1;
    end else if (gfx_mode_q) begin
      if (!ext_mode_q) begin
        push_framed(SyncCmd, CmdExtGraphic);
        ext_mode_q = 1'b1;
      end
      // Vertical address takes the row within the half screen; the
      // horizontal address takes the word column plus the half-select bit.
      push_framed(SyncCmd, {CmdGdramAddr, 4'h0} | {3'b000, row[4:0]});
      push_framed(SyncCmd, {CmdGdramAddr, row[5], col});
      push_framed(SyncData, pix[15:8]);
      push_framed(SyncData, pix[7:0]);
    end
    if (frame_q.size() != 0) begin
      frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] | 9'h100;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [8:0] exp_val,
                                 input logic [8:0] act_val);
    n_errors++;
    if (n_errors <= MaxReported) begin
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, exp_val[7:0], exp_val[8], act_val[7:0], act_val[8]);
    end
  endtask

  // Monitor for both channels, sampled at the rising edge before any of
  // this edge's updates land. Outputs are checked before the new request
  // is queued, since a request's first byte can never leave at the edge
  // that accepts it.
  always @(posedge clk_i) begin
    logic [8:0] exp_val;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_bytes_q.size() == 0) begin
          report_mismatch("byte with no request behind it", 9'h0, {last_o, serial_byte_o});
        end else begin
          exp_val = pending_bytes_q.pop_front();
          if (exp_val[7:0] !== serial_byte_o || exp_val[8] !== last_o) begin
            report_mismatch("serial byte mismatch", exp_val, {last_o, serial_byte_o});
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        frame_request(op_i, col_i, row_i, pixel_word_i);
        if (cur_hand_checked) begin
          frame_q.delete();
          for (int i = 0; i < cur_exp_count; i++) begin
            frame_q.push_back({(i == cur_exp_count - 1), cur_exp_bytes[119 - 8 * i -: 8]});
          end
        end
        foreach (frame_q[i]) pending_bytes_q.push_back(frame_q[i]);
      end
    end
  end

  // Presents one request and returns at the edge of its transfer, with
  // valid still high. The random hold-off before it lowers valid first.
  task automatic send_request(input logic op, input logic [2:0] col, input logic [5:0] row,
                              input logic [15:0] pix, input logic hand_checked,
                              input logic [3:0] exp_count, input logic [119:0] exp_bytes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    col_i            <= col;
    row_i            <= row;
    pixel_word_i     <= pix;
    cur_hand_checked <= hand_checked;
    cur_exp_count    <= exp_count;
    cur_exp_bytes    <= exp_bytes;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Holds the sender back until every predicted byte has been taken.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_bytes_q.size() != 0);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    logic op;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < RandPerPhase; k++) begin
      // Mostly draws, which carry all the varying content; an occasional
      // initialize drops the controller back out of extended mode.
      op = ($urandom_range(7) == 0) ? OpInit : OpDraw;
      send_request(op, 3'($urandom_range(7)), 6'($urandom_range(63)),
                   16'($urandom_range(65535)), 1'b0, 4'd0, 120'h0);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    op_i             = OpInit;
    col_i            = 3'd0;
    row_i            = 6'd0;
    pixel_word_i     = 16'h0000;
    out_ready_i      = 1'b0;
    cur_hand_checked = 1'b0;
    cur_exp_count    = 4'd0;
    cur_exp_bytes    = 120'h0;
    ext_mode_q       = 1'b0;
    gfx_mode_q       = 1'b0;
    n_errors         = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, back to back with the receiver always ready.
    for (int r = 0; r < DirRows; r++) begin
      send_request(DirTab[r].op, DirTab[r].col, DirTab[r].row, DirTab[r].pix,
                   DirTab[r].hand_checked, DirTab[r].exp_count, DirTab[r].exp_bytes);
    end
    hold_until_drained();

    // Random part: full rate, then a slow sender, then a slow receiver,
    // then light idling on both sides.
    run_random_phase(0, 0);
    run_random_phase(86, 0);
    hold_until_drained();
    run_random_phase(0, 86);
    run_random_phase(9, 9);
    hold_until_drained();

    repeat (DrainCycles) @(posedge clk_i);

    if (n_errors == 0 && pending_bytes_q.size() == 0) begin
      $display("lcd_gdram_write_serializer test passed");
    end else begin
      $display("lcd_gdram_write_serializer test failed");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("lcd_gdram_write_serializer test failed");
    $finish;
  end

endmodule
